/* hw/rtl/rsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants, codes and controller/datapath bundles for the allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int MAX_SECTORS   = 4096;
    localparam int TABLE_ENTRIES = 1024;
    localparam int SECTOR_W      = 12;
    localparam int KNOWN_W       = 13;
    localparam int IDX_W         = 10;
    localparam int MAP_WORD_W    = 32;
    localparam int MAP_DEPTH     = MAX_SECTORS / MAP_WORD_W;
    localparam int MAP_ADDR_W    = 7;
    localparam int BIT_W         = 5;
    localparam int NEED_W        = 10;
    localparam int RUN_W         = 9;
    localparam int ROW_SHIFT     = 5;
    localparam int SECTOR_SHIFT  = 12;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_ALLOC  = 2'd3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_BAD_IDX = 3'd1;
    localparam logic [2:0] STAT_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_TOO_BIG = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;
    localparam logic [2:0] STAT_DROPPED = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_TREAD,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PLACE,
        ST_USE_RD,
        ST_USE_WR,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        RES_INIT,
        RES_BAD_IDX,
        RES_LOAD,
        RES_LOOKUP,
        RES_TOO_BIG,
        RES_REUSE,
        RES_FULL,
        RES_ALLOC
    } res_kind_t;

    typedef struct packed {
        logic      latch_in;
        logic      clr_start;
        logic      clr_init;
        logic      clr_step;
        logic      load_write;
        logic      tbl_read;
        logic      free_start;
        logic      load_mark_start;
        logic      use_start;
        logic      mark_rd;
        logic      mark_wr;
        logic      scan_start;
        logic      scan_rd;
        logic      scan_chk;
        logic      alloc_write;
        logic      res_load;
        res_kind_t res_kind;
    } rsa_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] op;
        logic       idx_ok;
        logic       load_good;
        logic       need_big;
        logic       reuse;
        logic       old_zero;
        logic       mark_last;
        logic       rd_end;
        logic       chk_hit;
        logic       chk_end;
        logic       chk_same;
        logic       region_full;
        logic       out_block;
    } rsa_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/rsa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer: steps the datapath through clear, load, lookup and allocate.
// ----------------------------------------------------------------------------
module rsa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  rsa_pkg::rsa_sts_t      sts,
    output rsa_pkg::rsa_cmd_t      cmd
);

    rsa_pkg::state_t    state_reg, state_next;
    rsa_pkg::res_kind_t res_kind_reg, res_kind_next;
    logic               clr_init_reg, clr_init_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rsa_pkg::ST_CLEAR;
            res_kind_reg <= rsa_pkg::RES_INIT;
            clr_init_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_kind_reg <= res_kind_next;
            clr_init_reg <= clr_init_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        res_kind_next = res_kind_reg;
        clr_init_next = clr_init_reg;
        case (state_reg)
            rsa_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    if (clr_init_reg)
                    begin
                        res_kind_next = rsa_pkg::RES_INIT;
                        state_next    = rsa_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = rsa_pkg::ST_IDLE;
                    end
                end
            end
            rsa_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = rsa_pkg::ST_DECODE;
            end
            rsa_pkg::ST_DECODE:
            begin
                if (sts.op == rsa_pkg::OP_INIT)
                begin
                    clr_init_next = 1'b1;
                    state_next    = rsa_pkg::ST_CLEAR;
                end
                else if (!sts.idx_ok)
                begin
                    res_kind_next = rsa_pkg::RES_BAD_IDX;
                    state_next    = rsa_pkg::ST_RESULT;
                end
                else if (sts.op == rsa_pkg::OP_LOAD)
                begin
                    res_kind_next = rsa_pkg::RES_LOAD;
                    state_next    = sts.load_good ? rsa_pkg::ST_USE_RD : rsa_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = rsa_pkg::ST_TREAD;
                end
            end
            rsa_pkg::ST_TREAD:
            begin
                if (sts.op == rsa_pkg::OP_LOOKUP)
                begin
                    res_kind_next = rsa_pkg::RES_LOOKUP;
                    state_next    = rsa_pkg::ST_RESULT;
                end
                else if (sts.need_big)
                begin
                    res_kind_next = rsa_pkg::RES_TOO_BIG;
                    state_next    = rsa_pkg::ST_RESULT;
                end
                else if (sts.reuse)
                begin
                    res_kind_next = rsa_pkg::RES_REUSE;
                    state_next    = rsa_pkg::ST_RESULT;
                end
                else if (sts.old_zero)
                begin
                    state_next = rsa_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = rsa_pkg::ST_FREE_RD;
                end
            end
            rsa_pkg::ST_FREE_RD:
            begin
                state_next = rsa_pkg::ST_FREE_WR;
            end
            rsa_pkg::ST_FREE_WR:
            begin
                state_next = sts.mark_last ? rsa_pkg::ST_SCAN_RD : rsa_pkg::ST_FREE_RD;
            end
            rsa_pkg::ST_SCAN_RD:
            begin
                state_next = sts.rd_end ? rsa_pkg::ST_PLACE : rsa_pkg::ST_SCAN_CHK;
            end
            rsa_pkg::ST_SCAN_CHK:
            begin
                if (sts.chk_hit || sts.chk_end)
                    state_next = rsa_pkg::ST_PLACE;
                else if (!sts.chk_same)
                    state_next = rsa_pkg::ST_SCAN_RD;
            end
            rsa_pkg::ST_PLACE:
            begin
                if (sts.region_full)
                begin
                    res_kind_next = rsa_pkg::RES_FULL;
                    state_next    = rsa_pkg::ST_RESULT;
                end
                else
                begin
                    res_kind_next = rsa_pkg::RES_ALLOC;
                    state_next    = rsa_pkg::ST_USE_RD;
                end
            end
            rsa_pkg::ST_USE_RD:
            begin
                state_next = rsa_pkg::ST_USE_WR;
            end
            rsa_pkg::ST_USE_WR:
            begin
                state_next = sts.mark_last ? rsa_pkg::ST_RESULT : rsa_pkg::ST_USE_RD;
            end
            rsa_pkg::ST_RESULT:
            begin
                if (!sts.out_block)
                    state_next = rsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rsa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.res_kind = res_kind_reg;
        cmd.clr_init = clr_init_reg;
        in_stall     = 1'b1;
        case (state_reg)
            rsa_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            rsa_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            rsa_pkg::ST_DECODE:
            begin
                if (sts.op == rsa_pkg::OP_INIT)
                begin
                    cmd.clr_start = 1'b1;
                    cmd.clr_init  = 1'b1;
                end
                else if (sts.idx_ok && sts.op == rsa_pkg::OP_LOAD)
                begin
                    cmd.load_write      = 1'b1;
                    cmd.load_mark_start = sts.load_good;
                end
                else if (sts.idx_ok)
                begin
                    cmd.tbl_read = 1'b1;
                end
            end
            rsa_pkg::ST_TREAD:
            begin
                if (sts.op == rsa_pkg::OP_ALLOC && !sts.need_big && !sts.reuse)
                begin
                    cmd.free_start = !sts.old_zero;
                    cmd.scan_start = sts.old_zero;
                end
            end
            rsa_pkg::ST_FREE_RD:
            begin
                cmd.mark_rd = 1'b1;
            end
            rsa_pkg::ST_FREE_WR:
            begin
                cmd.mark_wr    = 1'b1;
                cmd.scan_start = sts.mark_last;
            end
            rsa_pkg::ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            rsa_pkg::ST_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
            end
            rsa_pkg::ST_PLACE:
            begin
                cmd.alloc_write = !sts.region_full;
                cmd.use_start   = !sts.region_full;
            end
            rsa_pkg::ST_USE_RD:
            begin
                cmd.mark_rd = 1'b1;
            end
            rsa_pkg::ST_USE_WR:
            begin
                cmd.mark_wr = 1'b1;
            end
            rsa_pkg::ST_RESULT:
            begin
                cmd.res_load = !sts.out_block;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == rsa_pkg::ST_IDLE))
        else $error("beat accepted outside idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !sts.out_block)
        else $error("result loaded over a held beat");

    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsa_pkg::ST_SCAN_CHK) |->
        ($past(state_reg) == rsa_pkg::ST_SCAN_RD || $past(state_reg) == rsa_pkg::ST_SCAN_CHK))
        else $error("bitmap checked without a read");

endmodule
`default_nettype wire

/* hw/rtl/rsa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_datapath
// Location table, free-sector bitmap, run marker, scanner and result register.
// ----------------------------------------------------------------------------
module rsa_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  rsa_pkg::rsa_cmd_t      cmd,
    output rsa_pkg::rsa_sts_t      sts,
    input  wire logic              cfg_wr_en,
    input  wire logic [12:0]       cfg_wr_data,
    input  wire logic [1:0]        operation,
    input  wire logic signed [11:0] chunk_x,
    input  wire logic signed [11:0] chunk_z,
    input  wire logic [19:0]       data_length,
    input  wire logic [31:0]       entry_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             status,
    output logic [11:0]            base_sector,
    output logic [7:0]             sector_count,
    output logic [7:0]             append_sectors,
    output logic                   table_updated
);

    localparam int IDX_SUM_W = 18;

    logic [31:0] tbl_mem [rsa_pkg::TABLE_ENTRIES];
    logic [31:0] map_mem [rsa_pkg::MAP_DEPTH];

    logic [rsa_pkg::KNOWN_W-1:0]  fs_reg, known_reg, known_next;
    logic [rsa_pkg::IDX_W-1:0]    cnt_reg;
    logic [1:0]                   op_reg;
    logic [rsa_pkg::IDX_W-1:0]    idx_reg;
    logic                         idx_ok_reg;
    logic [19:0]                  len_reg;
    logic [31:0]                  word_reg;
    logic [31:0]                  tbl_q_reg;
    logic [31:0]                  map_q_reg;
    logic [rsa_pkg::SECTOR_W-1:0] mark_base_reg;
    logic [7:0]                   mark_i_reg, mark_n_reg;
    logic                         mark_free_reg;
    logic [rsa_pkg::KNOWN_W-1:0]  slot_reg;
    logic [rsa_pkg::RUN_W-1:0]    run_reg;
    logic                         extend_reg;
    logic                         out_valid_reg;
    logic [2:0]                   status_reg;
    logic [11:0]                  base_reg;
    logic [7:0]                   count_reg, append_reg;
    logic                         updated_reg;

    logic [rsa_pkg::KNOWN_W-1:0]  fsc;
    logic signed [IDX_SUM_W-1:0]  idx_sum;
    logic [20:0]                  len4;
    logic [rsa_pkg::NEED_W-1:0]   need;
    logic [23:0]                  wb, ob;
    logic [7:0]                   wc, oc;
    logic                         load_good;
    logic [rsa_pkg::SECTOR_W-1:0] mark_s;
    logic [rsa_pkg::KNOWN_W-1:0]  mark_s1;
    logic [rsa_pkg::KNOWN_W-1:0]  scan_s, scan_s1;
    logic                         scan_bit;
    logic [rsa_pkg::RUN_W-1:0]    run_n;
    logic [rsa_pkg::KNOWN_W-1:0]  slot_n;
    logic [13:0]                  slot_end;
    logic [31:0]                  clr_pattern, mark_wdata;
    logic [rsa_pkg::MAP_ADDR_W-1:0] map_raddr;
    logic                         map_we;
    logic [rsa_pkg::MAP_ADDR_W-1:0] map_waddr;
    logic [31:0]                  map_wdata;
    logic                         tbl_we;
    logic [rsa_pkg::IDX_W-1:0]    tbl_waddr;
    logic [31:0]                  tbl_wdata;

    assign fsc = (fs_reg > rsa_pkg::KNOWN_W'(rsa_pkg::MAX_SECTORS))
               ? rsa_pkg::KNOWN_W'(rsa_pkg::MAX_SECTORS) : fs_reg;

    // x + z * row stride
    assign idx_sum = IDX_SUM_W'(chunk_x) + (IDX_SUM_W'(chunk_z) <<< rsa_pkg::ROW_SHIFT);

    assign len4 = {1'b0, len_reg} + 21'd4;
    assign need = rsa_pkg::NEED_W'(len4[20:rsa_pkg::SECTOR_SHIFT]) + rsa_pkg::NEED_W'(1);

    assign wb = word_reg[31:8];
    assign wc = word_reg[7:0];
    assign ob = tbl_q_reg[31:8];
    assign oc = tbl_q_reg[7:0];

    assign load_good = (wc != 8'd0) && (wb != 24'd0)
                    && (({1'b0, wb} + {17'd0, wc}) <= {12'd0, fsc});

    assign mark_s  = mark_base_reg + {4'd0, mark_i_reg};
    assign mark_s1 = {1'b0, mark_s} + rsa_pkg::KNOWN_W'(1);

    assign scan_s   = slot_reg + {4'd0, run_reg};
    assign scan_s1  = scan_s + rsa_pkg::KNOWN_W'(1);
    assign scan_bit = map_q_reg[scan_s[rsa_pkg::BIT_W-1:0]];
    assign run_n    = scan_bit ? (run_reg + rsa_pkg::RUN_W'(1)) : '0;
    assign slot_n   = scan_bit ? slot_reg : scan_s1;
    assign slot_end = {1'b0, slot_reg} + {4'd0, need};

    always_comb
    begin
        for (int j = 0; j < rsa_pkg::MAP_WORD_W; j++)
        begin
            clr_pattern[j] = cmd.clr_init
                && ({cnt_reg[rsa_pkg::MAP_ADDR_W-1:0], rsa_pkg::BIT_W'(j)} != '0)
                && ({1'b0, cnt_reg[rsa_pkg::MAP_ADDR_W-1:0], rsa_pkg::BIT_W'(j)} < fsc);
        end
        mark_wdata = map_q_reg;
        mark_wdata[mark_s[rsa_pkg::BIT_W-1:0]] = mark_free_reg;
    end

    // memory port steering
    always_comb
    begin
        map_raddr = cmd.scan_rd ? scan_s[rsa_pkg::SECTOR_W-1:rsa_pkg::BIT_W]
                                : mark_s[rsa_pkg::SECTOR_W-1:rsa_pkg::BIT_W];
        map_we    = 1'b0;
        map_waddr = mark_s[rsa_pkg::SECTOR_W-1:rsa_pkg::BIT_W];
        map_wdata = mark_wdata;
        if (cmd.clr_step)
        begin
            map_we    = (cnt_reg[rsa_pkg::IDX_W-1:rsa_pkg::MAP_ADDR_W] == '0);
            map_waddr = cnt_reg[rsa_pkg::MAP_ADDR_W-1:0];
            map_wdata = clr_pattern;
        end
        else if (cmd.mark_wr)
        begin
            map_we = 1'b1;
        end

        tbl_we    = cmd.clr_step || cmd.load_write || cmd.alloc_write;
        tbl_waddr = cmd.clr_step ? cnt_reg : idx_reg;
        if (cmd.clr_step)
            tbl_wdata = '0;
        else if (cmd.load_write)
            tbl_wdata = load_good ? word_reg : '0;
        else
            tbl_wdata = {12'd0, slot_reg[rsa_pkg::SECTOR_W-1:0], need[7:0]};
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        if (cmd.tbl_read)
            tbl_q_reg <= tbl_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (cmd.mark_rd || cmd.scan_rd)
            map_q_reg <= map_mem[map_raddr];
    end

    always_comb
    begin
        known_next = known_reg;
        if (cmd.clr_start)
            known_next = (fsc >= rsa_pkg::KNOWN_W'(2)) ? fsc : rsa_pkg::KNOWN_W'(1);
        else if (cmd.mark_wr && mark_s1 > known_reg)
            known_next = mark_s1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg        <= rsa_pkg::KNOWN_W'(1);
            known_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                fs_reg <= cfg_wr_data;
            known_reg <= known_next;
            if (cmd.clr_start)
                cnt_reg <= '0;
            else if (cmd.clr_step)
                cnt_reg <= cnt_reg + rsa_pkg::IDX_W'(1);
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg     <= operation;
            idx_reg    <= idx_sum[rsa_pkg::IDX_W-1:0];
            idx_ok_reg <= (idx_sum[IDX_SUM_W-1:rsa_pkg::IDX_W] == '0);
            len_reg    <= data_length;
            word_reg   <= entry_word;
        end

        if (cmd.load_mark_start)
        begin
            mark_base_reg <= wb[rsa_pkg::SECTOR_W-1:0];
            mark_n_reg    <= wc;
            mark_free_reg <= 1'b0;
            mark_i_reg    <= '0;
        end
        else if (cmd.free_start)
        begin
            mark_base_reg <= ob[rsa_pkg::SECTOR_W-1:0];
            mark_n_reg    <= oc;
            mark_free_reg <= 1'b1;
            mark_i_reg    <= '0;
        end
        else if (cmd.use_start)
        begin
            mark_base_reg <= slot_reg[rsa_pkg::SECTOR_W-1:0];
            mark_n_reg    <= need[7:0];
            mark_free_reg <= 1'b0;
            mark_i_reg    <= '0;
        end
        else if (cmd.mark_wr)
        begin
            mark_i_reg <= mark_i_reg + 8'd1;
        end

        if (cmd.scan_start)
        begin
            slot_reg   <= '0;
            run_reg    <= '0;
            extend_reg <= 1'b0;
        end
        else if (cmd.scan_rd)
        begin
            if (scan_s >= known_reg)
                extend_reg <= 1'b1;
        end
        else if (cmd.scan_chk)
        begin
            slot_reg <= slot_n;
            run_reg  <= run_n;
            if ({1'b0, run_n} < need && scan_s1 >= known_reg)
                extend_reg <= 1'b1;
        end

        if (cmd.res_load)
        begin
            status_reg  <= rsa_pkg::STAT_OK;
            base_reg    <= '0;
            count_reg   <= '0;
            append_reg  <= '0;
            updated_reg <= 1'b0;
            case (cmd.res_kind)
                rsa_pkg::RES_INIT:
                begin
                    status_reg <= rsa_pkg::STAT_OK;
                end
                rsa_pkg::RES_BAD_IDX:
                begin
                    status_reg <= rsa_pkg::STAT_BAD_IDX;
                end
                rsa_pkg::RES_LOAD:
                begin
                    if (word_reg == '0)
                        status_reg <= rsa_pkg::STAT_EMPTY;
                    else if (!load_good)
                        status_reg <= rsa_pkg::STAT_DROPPED;
                    else
                    begin
                        base_reg  <= wb[rsa_pkg::SECTOR_W-1:0];
                        count_reg <= wc;
                    end
                end
                rsa_pkg::RES_LOOKUP:
                begin
                    if (tbl_q_reg == '0)
                        status_reg <= rsa_pkg::STAT_EMPTY;
                    else
                    begin
                        base_reg  <= ob[rsa_pkg::SECTOR_W-1:0];
                        count_reg <= oc;
                    end
                end
                rsa_pkg::RES_TOO_BIG:
                begin
                    status_reg <= rsa_pkg::STAT_TOO_BIG;
                end
                rsa_pkg::RES_REUSE:
                begin
                    base_reg  <= ob[rsa_pkg::SECTOR_W-1:0];
                    count_reg <= oc;
                end
                rsa_pkg::RES_FULL:
                begin
                    status_reg <= rsa_pkg::STAT_FULL;
                end
                rsa_pkg::RES_ALLOC:
                begin
                    base_reg    <= slot_reg[rsa_pkg::SECTOR_W-1:0];
                    count_reg   <= need[7:0];
                    append_reg  <= extend_reg ? (need[7:0] - run_reg[7:0]) : 8'd0;
                    updated_reg <= 1'b1;
                end
                default:
                begin
                    status_reg <= rsa_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.clr_last    = (cnt_reg == '1);
        sts.op          = op_reg;
        sts.idx_ok      = idx_ok_reg;
        sts.load_good   = load_good;
        sts.need_big    = (need >= rsa_pkg::NEED_W'(256));
        sts.reuse       = (ob != '0) && ({2'd0, oc} == need);
        sts.old_zero    = (oc == 8'd0);
        sts.mark_last   = ((mark_i_reg + 8'd1) == mark_n_reg);
        sts.rd_end      = (scan_s >= known_reg);
        sts.chk_hit     = ({1'b0, run_n} >= need);
        sts.chk_end     = (scan_s1 >= known_reg);
        sts.chk_same    = (scan_s1[rsa_pkg::BIT_W-1:0] != '0);
        sts.region_full = (slot_end > 14'(rsa_pkg::MAX_SECTORS));
        sts.out_block   = out_valid_reg && out_stall;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign base_sector    = base_reg;
    assign sector_count   = count_reg;
    assign append_sectors = append_reg;
    assign table_updated  = updated_reg;

endmodule
`default_nettype wire

/* hw/rtl/region_sector_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// region_sector_allocator
// Chunk location table and free-sector bookkeeping with first-fit allocation.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------
//  in      | in_valid / in_stall       | operation, chunk_x, chunk_z,
//          |                           | data_length, entry_word
//  out     | out_valid / out_stall     | status, base_sector, sector_count,
//          |                           | append_sectors, table_updated
//  cfg     | cfg_wr_en                 | cfg_wr_data (file_sectors)
//
//  One item at a time. Load writes the table entry, then marks its sectors used.
//  Allocate frees any old run, then scans the 128x32 bitmap RAM first-fit, bit
//  by bit with one read per bitmap word, then marks the needed sectors used.
//  Init and reset sweep all 1024 table RAM entries, rewriting the 128 bitmap
//  words first; no beat is accepted during the sweep after reset.
//  A finished beat waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module region_sector_allocator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [12:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic signed [11:0] chunk_x,
    input  wire logic signed [11:0] chunk_z,
    input  wire logic [19:0]        data_length,
    input  wire logic [31:0]        entry_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [11:0]             base_sector,
    output logic [7:0]              sector_count,
    output logic [7:0]              append_sectors,
    output logic                    table_updated
);

    // controller -> datapath commands, datapath -> controller flags
    rsa_pkg::rsa_cmd_t cmd;
    rsa_pkg::rsa_sts_t sts;

    rsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table RAM, bitmap RAM, run marker, first-fit scanner, result register
    rsa_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .operation      (operation),
        .chunk_x        (chunk_x),
        .chunk_z        (chunk_z),
        .data_length    (data_length),
        .entry_word     (entry_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .base_sector    (base_sector),
        .sector_count   (sector_count),
        .append_sectors (append_sectors),
        .table_updated  (table_updated)
    );

endmodule
`default_nettype wire
